// File: sv/cde_pkg.sv
// cde_pkg: shared types, constants and index helpers for the circular deque engine.
// No dependencies; imported by circular_deque_engine_unit and cde_checker.
package cde_pkg;

    localparam int DEPTH  = 16;                 // slots in the ring, one always kept free
    localparam int IDX_W  = $clog2(DEPTH);      // slot index width
    localparam int SUM_W  = IDX_W + 5;          // room for index plus a 4-bit position

    localparam int WORD_W  = 64;
    localparam int OP_W    = 3;
    localparam int POS_W   = 4;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 4;
    localparam int TDATA_W = 72;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [OP_W-1:0]  op_t;
    typedef logic [STAT_W-1:0] stat_t;

    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_REAR  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_REAR   = 3'd3;
    localparam op_t OP_PEEK_FRONT = 3'd4;
    localparam op_t OP_PEEK_REAR  = 3'd5;
    localparam op_t OP_READ_POS   = 3'd6;
    localparam op_t OP_CLEAR      = 3'd7;

    localparam stat_t ST_OK     = 2'd0;
    localparam stat_t ST_EMPTY  = 2'd1;
    localparam stat_t ST_FULL   = 2'd2;
    localparam stat_t ST_BADPOS = 2'd3;

    localparam idx_t LAST_IDX = idx_t'(DEPTH - 1);
    localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(DEPTH);
    // count reported when full, masked to the count field
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH - 1);

    function automatic idx_t wrap_inc(input idx_t i);
        return (i == LAST_IDX) ? '0 : idx_t'(i + 1'b1);
    endfunction

    function automatic idx_t wrap_dec(input idx_t i);
        return (i == '0) ? LAST_IDX : idx_t'(i - 1'b1);
    endfunction

    // words held between front and rear
    function automatic idx_t held_count(input idx_t front, input idx_t rear);
        logic [IDX_W:0] diff;
        diff = (rear >= front) ? ({1'b0, rear} - {1'b0, front})
                               : ({1'b0, rear} + DEPTH_X - {1'b0, front});
        return diff[IDX_W-1:0];
    endfunction

endpackage

// File: sv/circular_deque_engine_unit.sv
// An accepted input word goes to the input register, then its result to the result
// register. Throughput: one request per cycle unless the result stalls, set by the
// single pass from the input register through the index logic and one slot read.
// Reset (rst_n low, asynchronous): front and rear indices to slot 0, both
// register stages empty; the slot store itself is not cleared.
// circular_deque_engine_unit: top level, depends on cde_pkg.
module circular_deque_engine_unit
    import cde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // request stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,  // operation[2:0], data_word[66:3],
                                              // position[70:67], zero[71]
    // result stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata   // read_word[63:0], status[65:64],
                                              // item_count[69:66], zero[71:70]
);

    // ---------------- input register ----------------
    logic              in_valid_reg;
    op_t               op_reg;
    logic [WORD_W-1:0] word_reg;
    logic [POS_W-1:0]  pos_reg;

    // ---------------- deque state ----------------
    idx_t              front_reg, front_next;
    idx_t              rear_reg, rear_next;
    logic [WORD_W-1:0] store_reg [DEPTH];

    // ---------------- result register ----------------
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_word_reg, out_word_next;
    stat_t              out_status_reg, out_status_next;
    logic [COUNT_W-1:0] out_count_reg;

    logic advance;      // input register moves into the result register this cycle
    logic in_take;

    // The input register refills whenever it empties or advances; a stalled result
    // with a request waiting in the input register holds off the next request.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= s_axis_tdata[2:0];
            word_reg <= s_axis_tdata[66:3];
            pos_reg  <= s_axis_tdata[70:67];
        end
    end

    // ---------------- request decode and index math ----------------
    logic              is_empty, is_full;
    idx_t              front_inc, front_dec, rear_inc, rear_dec;
    idx_t              held_now, held_next;
    logic              pos_ok;
    logic [SUM_W-1:0]  pos_sum, pos_wrap;
    idx_t              pos_idx;
    idx_t              rd_idx;
    logic [WORD_W-1:0] rd_data;
    logic              wr_en;
    idx_t              wr_idx;
    logic [SUM_W-1:0]  count_wide;

    assign is_empty  = (front_reg == rear_reg);
    assign rear_inc  = wrap_inc(rear_reg);
    assign rear_dec  = wrap_dec(rear_reg);
    assign front_inc = wrap_inc(front_reg);
    assign front_dec = wrap_dec(front_reg);
    assign is_full   = (rear_inc == front_reg);
    assign held_now  = held_count(front_reg, rear_reg);

    // position is one-based from the front; valid range 1..held
    assign pos_ok   = (pos_reg != '0) && (SUM_W'(pos_reg) <= SUM_W'(held_now));
    assign pos_sum  = SUM_W'(front_reg) + SUM_W'(pos_reg) - SUM_W'(1);
    // below twice DEPTH whenever the position is valid: one subtract wraps it
    assign pos_wrap = (pos_sum >= SUM_W'(DEPTH)) ? (pos_sum - SUM_W'(DEPTH)) : pos_sum;
    assign pos_idx  = pos_wrap[IDX_W-1:0];

    // one read port; the slot depends on the request
    always_comb
    begin
        unique case (op_reg)
            OP_POP_REAR, OP_PEEK_REAR: rd_idx = rear_dec;
            OP_READ_POS:               rd_idx = pos_idx;
            default:                   rd_idx = front_reg;
        endcase
    end

    assign rd_data = store_reg[rd_idx];

    always_comb
    begin
        front_next      = front_reg;
        rear_next       = rear_reg;
        out_word_next   = '0;
        out_status_next = ST_OK;
        wr_en           = 1'b0;
        wr_idx          = rear_reg;
        unique case (op_reg)
            OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    out_status_next = ST_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    wr_en      = 1'b1;
                    wr_idx     = front_dec;
                end
            end
            OP_PUSH_REAR:
            begin
                if (is_full)
                begin
                    out_status_next = ST_FULL;
                end
                else
                begin
                    rear_next = rear_inc;
                    wr_en     = 1'b1;
                    wr_idx    = rear_reg;
                end
            end
            OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    out_word_next = rd_data;
                    front_next    = front_inc;
                end
            end
            OP_POP_REAR:
            begin
                if (is_empty)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    out_word_next = rd_data;
                    rear_next     = rear_dec;
                end
            end
            OP_PEEK_FRONT, OP_PEEK_REAR:
            begin
                if (is_empty)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    out_word_next = rd_data;
                end
            end
            OP_READ_POS:
            begin
                if (pos_ok)
                begin
                    out_word_next = rd_data;
                end
                else
                begin
                    out_status_next = ST_BADPOS;
                end
            end
            OP_CLEAR:
            begin
                front_next = '0;
                rear_next  = '0;
            end
            default:
            begin
                front_next = front_reg;
            end
        endcase
    end

    // count after the request, masked to the 4-bit field
    assign held_next  = held_count(front_next, rear_next);
    assign count_wide = SUM_W'(held_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
        end
        else if (advance)
        begin
            front_reg <= front_next;
            rear_reg  <= rear_next;
        end
    end

    // slot store: no reset, only written slots are ever read
    always_ff @(posedge clk)
    begin
        if (advance && wr_en)
        begin
            store_reg[wr_idx] <= word_reg;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg   <= out_word_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= count_wide[COUNT_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_count_reg, out_status_reg, out_word_reg};

endmodule

// File: sv/cde_checker.sv
// cde_checker: port-level checks on the result stream of circular_deque_engine_unit.
// Depends on cde_pkg; bound to the top level at the end of this file.
module cde_checker
    import cde_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    logic [WORD_W-1:0]  res_word;
    stat_t              res_status;
    logic [COUNT_W-1:0] res_count;

    assign res_word   = m_axis_tdata[63:0];
    assign res_status = m_axis_tdata[65:64];
    assign res_count  = m_axis_tdata[69:66];

    // any refused or failed request returns a zero word
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_status != ST_OK) |-> (res_word == '0))
        else $error("nonzero word on failed request");

    // an empty flag means nothing is held
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_status == ST_EMPTY) |-> (res_count == '0))
        else $error("empty status with nonzero count");

    // a refused insert reports a full ring
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res_status == ST_FULL) |-> (res_count == FULL_COUNT))
        else $error("full status with wrong count");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

bind circular_deque_engine_unit cde_checker u_cde_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
